// ----- hdl/rsre_pkg.sv -----
// Shared types and constants of the round-trip smoothed rate estimator.
package rsre_pkg;

  // Field widths fixed by the interface.
  localparam int RTT_W      = 32;
  localparam int BYTES_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int BLOCK_W    = 25;
  localparam int CFG_DATA_W = 32;
  localparam int RATE_OUT_W = 48;

  // Microseconds per second, and the width that holds it.
  localparam int USEC_W = 20;
  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

  // bytes * gain * 1e6 before any scaling.
  localparam int PROD_W = BYTES_W + GAIN_W + USEC_W;

  // Eight bits per byte over the 256 of the Q8.8 gain leaves a net shift right by five.
  localparam int GAIN_BIT_SHIFT = 5;

  // Eight bits per byte in the block size divisor.
  localparam int BYTE_BIT_SHIFT = 3;

  // Reset values of the configuration registers.
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 16'd8192;
  localparam logic [GAIN_W-1:0]   GAIN_RESET     = 16'd256;
  localparam logic [BLOCK_W-1:0]  BLOCK_RESET    = 25'd4096;
  localparam logic [RTT_W-1:0]    INIT_RTT_RESET = 32'd1000;

  localparam int MUL_CNT_W = $clog2(WEIGHT_W);

  typedef enum logic [1:0] {
    REG_SMOOTHING_WEIGHT = 2'd0,
    REG_RATE_GAIN        = 2'd1,
    REG_BLOCK_BYTES      = 2'd2,
    REG_INITIAL_RTT      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RTT_W-1:0]   rtt_us;
    logic [BYTES_W-1:0] moved_bytes;
  } sample_t;

  typedef struct packed {
    logic [RATE_OUT_W-1:0] rate_bps;
    logic [RATE_OUT_W-1:0] blocks_per_second;
    logic [RTT_W-1:0]      smoothed_rtt_us;
    logic                  rtt_zero;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPDATE,
    ST_CHECK,
    ST_DIV_RATE,
    ST_BLK_START,
    ST_DIV_BLK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_step;
    logic update;
    logic rate_max;
    logic div_rate_start;
    logic rate_load;
    logic div_blk_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic s_zero;
    logic div_done;
  } status_t;

endpackage

// ----- hdl/rsre_div.sv -----
// Serial restoring divider, one quotient bit per cycle, with quotient overflow flag.
module rsre_div #(
  parameter int NUM_W = 79,
  parameter int DEN_W = 48,
  parameter int QUO_W = 48,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  input  logic [CNT_W-1:0] count,
  output logic             done,
  output logic [QUO_W-1:0] quotient,
  output logic             overflow
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, num[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= count;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
      overflow <= 1'b0;
    end else if (busy) begin
      num      <= num << 1;
      rem      <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quotient <= {quotient[QUO_W-2:0], fits};
      overflow <= overflow | quotient[QUO_W-1];
    end
  end

endmodule

// ----- hdl/rsre_ctrl.sv -----
// Sequencing state machine of the rate estimator and the result valid flag.
module rsre_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  rsre_pkg::status_t st,
  output rsre_pkg::cmd_t    cmd
);

  rsre_pkg::state_t                state, state_next;
  logic [rsre_pkg::MUL_CNT_W-1:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rsre_pkg::ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      rsre_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = rsre_pkg::ST_MUL;
        end
      end
      rsre_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + rsre_pkg::MUL_CNT_W'(1);
        if (cnt == rsre_pkg::MUL_CNT_W'(rsre_pkg::WEIGHT_W - 1)) begin
          state_next = rsre_pkg::ST_UPDATE;
        end
      end
      rsre_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = rsre_pkg::ST_CHECK;
      end
      rsre_pkg::ST_CHECK: begin
        if (st.s_zero) begin
          cmd.rate_max = 1'b1;
          state_next   = rsre_pkg::ST_BLK_START;
        end else begin
          cmd.div_rate_start = 1'b1;
          state_next         = rsre_pkg::ST_DIV_RATE;
        end
      end
      rsre_pkg::ST_DIV_RATE: begin
        if (st.div_done) begin
          cmd.rate_load = 1'b1;
          state_next    = rsre_pkg::ST_BLK_START;
        end
      end
      rsre_pkg::ST_BLK_START: begin
        cmd.div_blk_start = 1'b1;
        state_next        = rsre_pkg::ST_DIV_BLK;
      end
      rsre_pkg::ST_DIV_BLK: begin
        if (st.div_done) begin
          state_next = rsre_pkg::ST_DONE;
        end
      end
      rsre_pkg::ST_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = rsre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsre_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/rsre_dp.sv -----
// Datapath: smoothed round-trip time, serial weight multiply, rate and block divisions.
module rsre_dp #(
  parameter int RTT_FRAC_BITS = 16,
  parameter int RATE_WIDTH    = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rsre_pkg::cmd_t                    cmd,
  output rsre_pkg::status_t                 st,
  input  rsre_pkg::sample_t                 sample,
  input  logic [rsre_pkg::WEIGHT_W-1:0]     weight,
  input  logic [rsre_pkg::GAIN_W-1:0]       gain,
  input  logic [rsre_pkg::BLOCK_W-1:0]      block_bytes,
  input  logic                              init_load,
  input  logic [rsre_pkg::RTT_W-1:0]        init_rtt,
  output rsre_pkg::result_t                 result
);

  localparam int SW    = rsre_pkg::RTT_W + RTT_FRAC_BITS;
  localparam int AW    = SW + 1 + rsre_pkg::WEIGHT_W;
  localparam int NUM_W = rsre_pkg::PROD_W + RTT_FRAC_BITS - rsre_pkg::GAIN_BIT_SHIFT;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int BG_W  = rsre_pkg::BYTES_W + rsre_pkg::GAIN_W;

  logic [SW-1:0]                     s;
  logic signed [SW:0]                diff;
  logic signed [AW-1:0]              mcand;
  logic signed [AW-1:0]              acc;
  logic signed [AW-1:0]              s_sum;
  logic [rsre_pkg::WEIGHT_W-1:0]     wsh;
  logic [rsre_pkg::BYTES_W-1:0]      bytes_q;
  logic [BG_W-1:0]                   bg;
  logic [rsre_pkg::PROD_W-1:0]       prod;
  logic [RATE_WIDTH-1:0]             rate;
  logic                              zero;
  logic [rsre_pkg::BLOCK_W-1:0]      bb_eff;

  logic                              div_start;
  logic [NUM_W-1:0]                  div_num;
  logic [SW-1:0]                     div_den;
  logic [CNT_W-1:0]                  div_cnt;
  logic                              div_done;
  logic [RATE_WIDTH-1:0]             div_quo;
  logic                              div_ovf;

  // New sample minus the current smoothed time, both in Q32.F.
  assign diff  = $signed({1'b0, sample.rtt_us, {RTT_FRAC_BITS{1'b0}}}) - $signed({1'b0, s});
  assign s_sum = $signed(AW'(s)) + (acc >>> rsre_pkg::WEIGHT_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      s <= SW'(rsre_pkg::INIT_RTT_RESET) << RTT_FRAC_BITS;
    end else if (init_load) begin
      s <= SW'(init_rtt) << RTT_FRAC_BITS;
    end else if (cmd.update) begin
      s <= s_sum[SW-1:0];
    end
  end

  // Shift-add multiply of weight by the difference, one weight bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mcand   <= AW'(diff);
      acc     <= '0;
      wsh     <= weight;
      bytes_q <= sample.moved_bytes;
    end else if (cmd.mul_step) begin
      if (wsh[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand <<< 1;
      wsh   <= wsh >> 1;
    end
  end

  // Two registered products: bytes*gain, then *1e6.
  always_ff @(posedge clk) begin
    bg   <= bytes_q * gain;
    prod <= bg * rsre_pkg::USEC_PER_SEC;
  end

  assign bb_eff    = (block_bytes == '0) ? rsre_pkg::BLOCK_W'(1) : block_bytes;
  assign div_start = cmd.div_rate_start | cmd.div_blk_start;

  always_comb begin
    if (cmd.div_blk_start) begin
      div_num = NUM_W'(rate) << (NUM_W - RATE_WIDTH);
      div_den = SW'(bb_eff) << rsre_pkg::BYTE_BIT_SHIFT;
      div_cnt = CNT_W'(RATE_WIDTH);
    end else begin
      div_num = NUM_W'(prod) << (RTT_FRAC_BITS - rsre_pkg::GAIN_BIT_SHIFT);
      div_den = s;
      div_cnt = CNT_W'(NUM_W);
    end
  end

  rsre_div #(
    .NUM_W (NUM_W),
    .DEN_W (SW),
    .QUO_W (RATE_WIDTH),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .count    (div_cnt),
    .done     (div_done),
    .quotient (div_quo),
    .overflow (div_ovf)
  );

  always_ff @(posedge clk) begin
    if (cmd.rate_max) begin
      rate <= '1;
      zero <= 1'b1;
    end else if (cmd.div_rate_start) begin
      zero <= 1'b0;
    end else if (cmd.rate_load) begin
      rate <= div_ovf ? '1 : div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.rate_bps          <= rsre_pkg::RATE_OUT_W'(rate);
      result.blocks_per_second <= (div_quo == '0) ? rsre_pkg::RATE_OUT_W'(1)
                                                  : rsre_pkg::RATE_OUT_W'(div_quo);
      result.smoothed_rtt_us   <= s[SW-1:RTT_FRAC_BITS];
      result.rtt_zero          <= zero;
    end
  end

  assign st.s_zero   = (s == '0);
  assign st.div_done = div_done;

endmodule

// ----- hdl/rtt_smoothed_rate_estimator_unit.sv -----
// A sample beat runs through the weight multiply, the update and the serial divider, which
// gives one quotient bit per cycle and serves the rate and block divisions in turn; a zero
// smoothed time skips the rate division. The rate dividend is 63 + RTT_FRAC_BITS bits wide.
// One sample at a time: a new sample beat is taken only after the last result is loaded.
// Reset (synchronous, active high) loads the register defaults, sets the smoothed time
// to 1000 us and empties the result register; there is no clearing pass.
module rtt_smoothed_rate_estimator_unit #(
  parameter int RTT_FRAC_BITS = 16,
  parameter int RATE_WIDTH    = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  rsre_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output rsre_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [rsre_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [rsre_pkg::RATE_OUT_W-1:0] RATE_MAX_OUT =
    rsre_pkg::RATE_OUT_W'({RATE_WIDTH{1'b1}});

  // Configuration registers. Writes must arrive only while the unit is idle (the user's
  // duty; the unit does not enforce it), as the datapath reads them directly without a shadow copy.
  logic [rsre_pkg::WEIGHT_W-1:0] smoothing_weight;
  logic [rsre_pkg::GAIN_W-1:0]   rate_gain;
  logic [rsre_pkg::BLOCK_W-1:0]  block_bytes;
  logic                          init_load;

  rsre_pkg::cmd_t    cmd;
  rsre_pkg::status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_weight <= rsre_pkg::WEIGHT_RESET;
      rate_gain        <= rsre_pkg::GAIN_RESET;
      block_bytes      <= rsre_pkg::BLOCK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rsre_pkg::REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[rsre_pkg::WEIGHT_W-1:0];
        rsre_pkg::REG_RATE_GAIN:        rate_gain        <= cfg_data[rsre_pkg::GAIN_W-1:0];
        rsre_pkg::REG_BLOCK_BYTES:      block_bytes      <= cfg_data[rsre_pkg::BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // Writing the initial round-trip time restarts the smoothed estimate from it.
  assign init_load = cfg_we && (cfg_index == rsre_pkg::REG_INITIAL_RTT);

  // The controller walks each sample through multiply, update, rate division (skipped for a zero
  // smoothed time) and block division; the result register lets a new sample beat be taken while a result still waits.
  rsre_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .st           (st),
    .cmd          (cmd)
  );

  rsre_dp #(
    .RTT_FRAC_BITS (RTT_FRAC_BITS),
    .RATE_WIDTH    (RATE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .sample      (sample),
    .weight      (smoothing_weight),
    .gain        (rate_gain),
    .block_bytes (block_bytes),
    .init_load   (init_load),
    .init_rtt    (cfg_data[rsre_pkg::RTT_W-1:0]),
    .result      (result)
  );

  // A new result is never written over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && !result_ready))
    else $error("result register overwritten while a beat was pending");

  // A zero smoothed time always comes with the saturated rate.
  a_zero_forces_max: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.rtt_zero) |-> (result.rate_bps == RATE_MAX_OUT))
    else $error("rtt_zero set without maximum rate");

  // Blocks per second is clamped to at least one.
  a_blocks_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.blocks_per_second != '0))
    else $error("blocks_per_second is zero");

endmodule
